// ----- rtl/lhbp_pkg.sv -----
// Shared types and constants for the local history branch predictor.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package lhbp_pkg;

    // The counter column is taken from the low pc bits, the history row from the bits above.
    localparam int unsigned COL_W = 3;
    localparam int unsigned ROW_W = 9;
    localparam int unsigned HIST_DEPTH = 1 << ROW_W;

    // Stream widths.
    localparam int unsigned PC_W = 32;
    localparam int unsigned IN_DATA_W = 40;
    localparam int unsigned OUT_DATA_W = 8;

    // Counter codes.
    localparam logic [1:0] CTR_STRONG_NT = 2'b00;
    localparam logic [1:0] CTR_WEAK_NT = 2'b01;
    localparam logic [1:0] CTR_WEAK_T = 2'b10;
    localparam logic [1:0] CTR_STRONG_T = 2'b11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic capture;
        logic ctr_rd;
        logic commit;
    } lhbp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
    } lhbp_status_t;

endpackage

// ----- rtl/lhbp_ctrl.sv -----
// Controller for the local history branch predictor: clearing pass, request
// sequencing and the output valid flag. Depends on lhbp_pkg.
`timescale 1ns / 1ps

module lhbp_ctrl
    import lhbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  lhbp_status_t status,
    output lhbp_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HIST,
        ST_CTR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = ST_HIST;
                end
            end
            ST_HIST:
            begin
                cmd.ctr_rd = 1'b1;
                state_next = ST_CTR;
            end
            ST_CTR:
            begin
                // The result may only be loaded once the previous one has been taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/lhbp_datapath.sv -----
// Datapath for the local history branch predictor: history and counter memories,
// request registers, counter update and the result register. Depends on lhbp_pkg.
`timescale 1ns / 1ps

module lhbp_datapath
    import lhbp_pkg::*;
#(
    parameter int unsigned HISTORY_LENGTH = 6
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  lhbp_cmd_t        cmd,
    output lhbp_status_t     status,
    input  logic             action,
    input  logic [PC_W-1:0]  pc,
    input  logic             actual_taken,
    input  logic             predicted_taken,
    output logic             predict_taken
);

    localparam int unsigned CTR_AW = HISTORY_LENGTH + COL_W;
    localparam int unsigned CTR_DEPTH = 1 << CTR_AW;
    localparam int unsigned CLR_W = (CTR_AW > ROW_W) ? CTR_AW : ROW_W;
    localparam int unsigned SWEEP = 1 << CLR_W;

    logic [HISTORY_LENGTH-1:0] hist_mem [HIST_DEPTH];
    logic [1:0]                ctr_mem [CTR_DEPTH];

    logic [CLR_W-1:0]          clr_cnt_reg;
    logic [ROW_W-1:0]          row_reg;
    logic [COL_W-1:0]          col_reg;
    logic                      action_reg;
    logic                      actual_reg;
    logic                      predicted_reg;
    logic [HISTORY_LENGTH-1:0] hist_rd_reg;
    logic [1:0]                ctr_rd_reg;
    logic                      predict_reg;

    logic [CTR_AW-1:0]         ctr_addr;
    logic [HISTORY_LENGTH:0]   hist_shift;
    logic [1:0]                ctr_new;
    logic                      hist_we;
    logic [ROW_W-1:0]          hist_waddr;
    logic [HISTORY_LENGTH-1:0] hist_wdata;
    logic                      ctr_we;
    logic [CTR_AW-1:0]         ctr_waddr;
    logic [1:0]                ctr_wdata;

    assign ctr_addr = {hist_rd_reg, col_reg};
    assign hist_shift = {hist_rd_reg, actual_reg};
    assign status.clr_last = (clr_cnt_reg == CLR_W'(SWEEP - 1));

    always_comb
    begin
        ctr_new = ctr_rd_reg;
        if (actual_reg == predicted_reg)
        begin
            // A correct prediction makes a weak counter strong.
            if (ctr_rd_reg == CTR_WEAK_T)
            begin
                ctr_new = CTR_STRONG_T;
            end
            else if (ctr_rd_reg == CTR_WEAK_NT)
            begin
                ctr_new = CTR_STRONG_NT;
            end
        end
        else if (predicted_reg)
        begin
            if (ctr_rd_reg != CTR_STRONG_NT)
            begin
                ctr_new = ctr_rd_reg - 2'd1;
            end
        end
        else
        begin
            if (ctr_rd_reg != CTR_STRONG_T)
            begin
                ctr_new = ctr_rd_reg + 2'd1;
            end
        end
    end

    // The two memories share one sweep counter; each is written while the count is in range.
    always_comb
    begin
        if (cmd.clr_step)
        begin
            hist_we = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(HIST_DEPTH));
            hist_waddr = clr_cnt_reg[ROW_W-1:0];
            hist_wdata = '0;
            ctr_we = ({1'b0, clr_cnt_reg} < (CLR_W + 1)'(CTR_DEPTH));
            ctr_waddr = clr_cnt_reg[CTR_AW-1:0];
            ctr_wdata = CTR_WEAK_NT;
        end
        else
        begin
            hist_we = cmd.commit && action_reg;
            hist_waddr = row_reg;
            hist_wdata = hist_shift[HISTORY_LENGTH-1:0];
            ctr_we = cmd.commit && action_reg;
            ctr_waddr = ctr_addr;
            ctr_wdata = ctr_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + CLR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        if (cmd.capture)
        begin
            hist_rd_reg <= hist_mem[pc[COL_W +: ROW_W]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctr_we)
        begin
            ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (cmd.ctr_rd)
        begin
            ctr_rd_reg <= ctr_mem[ctr_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            row_reg <= pc[COL_W +: ROW_W];
            col_reg <= pc[COL_W-1:0];
            action_reg <= action;
            actual_reg <= actual_taken;
            predicted_reg <= predicted_taken;
        end
        if (cmd.commit)
        begin
            predict_reg <= ctr_rd_reg[1];
        end
    end

    assign predict_taken = predict_reg;

endmodule

// ----- rtl/local_history_branch_predictor.sv -----
// Operation: a request is accepted in the idle state; the history read, the dependent counter
// read and the commit (with write-back when action is set) follow one after the other. The commit
// waits until the previous result has been taken, and the result is held in a register until
// taken. A new request is accepted only once the last one has been committed.
// Reset: history cleared to zero and counters set to weakly not taken by a clearing pass that
// sweeps every address of the larger memory, during which no request is accepted.
`timescale 1ns / 1ps

module local_history_branch_predictor
    import lhbp_pkg::*;
#(
    parameter int unsigned HISTORY_LENGTH = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Bits from the lowest up: pc[31:0], actual_taken, predicted_taken, zero fill.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Bits from the lowest up: action.
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Bits from the lowest up: predict_taken, zero fill.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    lhbp_cmd_t    cmd;
    lhbp_status_t status;
    logic         predict_taken;

    lhbp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    lhbp_datapath #(
        .HISTORY_LENGTH (HISTORY_LENGTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .action          (s_axis_tuser),
        .pc              (s_axis_tdata[PC_W-1:0]),
        .actual_taken    (s_axis_tdata[PC_W]),
        .predicted_taken (s_axis_tdata[PC_W+1]),
        .predict_taken   (predict_taken)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - 1){1'b0}}, predict_taken};

endmodule
